[src/dsa_pkg.sv]
// Shared types and codes for the disk sector allocator.
`default_nettype none

package dsa_pkg;

  // Operation codes carried by the opcode field.
  localparam logic [2:0] OP_INIT        = 3'd0;
  localparam logic [2:0] OP_ALLOC_BYTES = 3'd1;
  localparam logic [2:0] OP_ALLOC_ONE   = 3'd2;
  localparam logic [2:0] OP_FREE_OWNER  = 3'd3;
  localparam logic [2:0] OP_FREE_INDEX  = 3'd4;
  localparam logic [2:0] OP_QUERY       = 3'd5;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] REG_RESERVED_SECTORS = 3'd0;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  owner_id;
    logic [17:0] request_bytes;
    logic [7:0]  sector_number;
  } in_t;

  typedef struct packed {
    logic [7:0]  last_sector;
    logic [8:0]  sectors_taken;
    logic [17:0] free_bytes;
    logic        status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // latch the accepted word and rewind the sweep
    logic issue;  // read the next sector entry
    logic load;   // capture the result word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_op;   // the word at the input needs a pass over the table
    logic last_addr;  // the sweep address is the last sector
  } stat_t;

endpackage

`default_nettype wire

[src/dsa_ctrl.sv]
// Controller state machine for the disk sector allocator.
`default_nettype none

module dsa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire dsa_pkg::stat_t stat_i,
  output dsa_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_CLEAR_END = 3'd1;
  localparam logic [2:0] S_IDLE      = 3'd2;
  localparam logic [2:0] S_SWEEP     = 3'd3;
  localparam logic [2:0] S_SWEEP_END = 3'd4;
  localparam logic [2:0] S_FINISH    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       start, load;

  assign start = (state_q == S_IDLE) && in_valid_i;
  // The result register frees up in the same cycle its word is taken.
  assign load  = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.last_addr) state_d = S_CLEAR_END;
      end
      S_CLEAR_END: state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) state_d = stat_i.sweep_op ? S_SWEEP : S_FINISH;
      end
      S_SWEEP: begin
        if (stat_i.last_addr) state_d = S_SWEEP_END;
      end
      S_SWEEP_END: state_d = S_FINISH;
      S_FINISH: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.start = start;
  assign cmd_o.issue = (state_q == S_CLEAR) || (state_q == S_SWEEP);
  assign cmd_o.load  = load;

endmodule

`default_nettype wire

[src/dsa_dpath.sv]
// Datapath of the disk sector allocator: sector table, sweep pipeline and counters.
`default_nettype none

module dsa_dpath #(
  parameter int NUM_SECTORS      = 256,
  parameter int BYTES_PER_SECTOR = 512,
  parameter int OWNER_BITS       = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dsa_pkg::in_t   item_i,
  input  wire logic [8:0]     reserved_i,
  input  wire dsa_pkg::cmd_t  cmd_i,
  output dsa_pkg::stat_t      stat_o,
  output dsa_pkg::out_t       out_data_o
);

  localparam int AW = $clog2(NUM_SECTORS);
  localparam int FW = $clog2(NUM_SECTORS + 1);
  localparam int PW = FW + 17;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SECTORS - 1);
  localparam logic [17:0]   SECTOR_BYTES = 18'(BYTES_PER_SECTOR);

  typedef enum logic [2:0] {
    MODE_CLEAR,
    MODE_INIT,
    MODE_ALLOC,
    MODE_FREE_OWNER,
    MODE_FREE_INDEX,
    MODE_QUERY
  } mode_e;

  // Each entry holds the full mark above the owner tag.
  logic [OWNER_BITS:0]   mem_q [NUM_SECTORS];
  logic [OWNER_BITS:0]   rd_q;

  mode_e                 mode_q, mode_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [AW-1:0]         pend_addr_q;
  logic                  pend_q;
  logic [OWNER_BITS-1:0] own_q;
  logic [7:0]            sec_q;
  logic [17:0]           rem_q, rem_d;
  logic [FW-1:0]         free_q, free_d;
  logic [8:0]            taken_q, taken_d;
  logic [7:0]            last_q, last_d;
  dsa_pkg::out_t         out_q;

  logic                  we;
  logic [OWNER_BITS:0]   wdata;
  logic                  ent_full;
  logic [OWNER_BITS-1:0] ent_owner;
  logic [23:0]           owner_wide;
  logic [PW-1:0]         bytes_prod;
  logic                  init_full;

  assign owner_wide = {16'b0, item_i.owner_id};
  assign ent_full   = rd_q[OWNER_BITS];
  assign ent_owner  = rd_q[OWNER_BITS-1:0];
  assign init_full  = 16'(pend_addr_q) < 16'(reserved_i);

  always_comb begin
    case (item_i.opcode)
      dsa_pkg::OP_INIT:        mode_d = MODE_INIT;
      dsa_pkg::OP_ALLOC_BYTES: mode_d = MODE_ALLOC;
      dsa_pkg::OP_ALLOC_ONE:   mode_d = MODE_ALLOC;
      dsa_pkg::OP_FREE_OWNER:  mode_d = MODE_FREE_OWNER;
      dsa_pkg::OP_FREE_INDEX:  mode_d = MODE_FREE_INDEX;
      default:                 mode_d = MODE_QUERY;
    endcase
  end

  assign stat_o.sweep_op  = (mode_d != MODE_QUERY);
  assign stat_o.last_addr = (addr_q == LAST_ADDR);

  // Second stage of the sweep: decide the write for the entry read last cycle.
  always_comb begin
    we      = 1'b0;
    wdata   = '0;
    free_d  = free_q;
    taken_d = taken_q;
    last_d  = last_q;
    rem_d   = rem_q;
    if (pend_q) begin
      case (mode_q)
        MODE_CLEAR: begin
          we     = 1'b1;
          free_d = free_q + 1'b1;
        end
        MODE_INIT: begin
          we    = 1'b1;
          wdata = {init_full, {OWNER_BITS{1'b0}}};
          if (!init_full) free_d = free_q + 1'b1;
        end
        MODE_ALLOC: begin
          if (!ent_full && (rem_q != '0)) begin
            we     = 1'b1;
            wdata  = {1'b1, own_q};
            free_d = free_q - 1'b1;
            last_d = 8'(pend_addr_q);
            if (!(&taken_q)) taken_d = taken_q + 1'b1;
            rem_d  = (rem_q <= SECTOR_BYTES) ? '0 : rem_q - SECTOR_BYTES;
          end
        end
        MODE_FREE_OWNER: begin
          if (ent_full && (ent_owner == own_q)) begin
            we     = 1'b1;
            free_d = free_q + 1'b1;
          end
        end
        MODE_FREE_INDEX: begin
          if (16'(pend_addr_q) == 16'(sec_q)) begin
            we = 1'b1;
            if (ent_full) free_d = free_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.start) begin
      taken_d = '0;
      last_d  = '0;
      rem_d   = (item_i.opcode == dsa_pkg::OP_ALLOC_ONE) ? 18'd1 : item_i.request_bytes;
      if (mode_d == MODE_INIT) free_d = '0;
    end
  end

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.start) begin
      addr_d = '0;
    end else if (cmd_i.issue) begin
      addr_d = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CLEAR;
      addr_q  <= '0;
      pend_q  <= 1'b0;
      free_q  <= '0;
      taken_q <= '0;
      last_q  <= '0;
      rem_q   <= '0;
    end else begin
      if (cmd_i.start) mode_q <= mode_d;
      addr_q  <= addr_d;
      pend_q  <= cmd_i.issue;
      free_q  <= free_d;
      taken_q <= taken_d;
      last_q  <= last_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      own_q <= owner_wide[OWNER_BITS-1:0];
      sec_q <= item_i.sector_number;
    end
    if (cmd_i.issue) pend_addr_q <= addr_q;
  end

  // Sector table: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[pend_addr_q] <= wdata;
    if (cmd_i.issue) rd_q <= mem_q[addr_q];
  end

  assign bytes_prod = PW'(free_q) * PW'(BYTES_PER_SECTOR);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.last_sector   <= last_q;
      out_q.sectors_taken <= taken_q;
      out_q.free_bytes    <= bytes_prod[17:0];
      out_q.status        <= (mode_q == MODE_ALLOC) && (rem_q != '0);
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

[src/disk_sector_allocator.sv]
// Top level of the disk sector allocator: configuration register, controller and datapath.
// Reset clears the sector table in one pass over every entry before any word is taken.
// Init, allocate and free words take one pass over the sector table, which has one read
// and one write port, from acceptance to result; a query skips the pass.
// One word is in work at a time; the next is accepted while its result waits.
// reserved_sectors resets to 1; a reset empties every sector without reserving any.
`default_nettype none

module disk_sector_allocator #(
  parameter int NUM_SECTORS      = 256,
  parameter int BYTES_PER_SECTOR = 512,
  parameter int OWNER_BITS       = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dsa_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dsa_pkg::out_t      out_data_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [8:0]     reserved_q;
  dsa_pkg::cmd_t  cmd;
  dsa_pkg::stat_t stat;
  logic           reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == dsa_pkg::REG_RESERVED_SECTORS[2]);
  assign prdata  = reg_hit ? {23'b0, reserved_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= 9'd1;
    end else if (psel && penable && pwrite && reg_hit) begin
      reserved_q <= pwdata[8:0];
    end
  end

  dsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsa_dpath #(
    .NUM_SECTORS      (NUM_SECTORS),
    .BYTES_PER_SECTOR (BYTES_PER_SECTOR),
    .OWNER_BITS       (OWNER_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_data_i),
    .reserved_i (reserved_q),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
